>>> src/pssm_pkg.sv
// Package with types, constants and helpers of the priority spool slot manager.
`default_nettype none
package pssm_pkg;
   localparam int SLOTS = 16;
   localparam int RETRY_W = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_SELECT = 3'd1;
   localparam logic [2:0] CMD_ACK    = 3'd2;
   localparam logic [2:0] CMD_FAIL   = 3'd3;
   localparam logic [2:0] CMD_RECLAIM = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   localparam logic [1:0] COND_ERASED    = 2'd0;
   localparam logic [1:0] COND_COMMITTED = 2'd1;
   localparam logic [1:0] COND_CONSUMED  = 2'd2;

   localparam logic [0:0] REG_CRIT = 1'd0;
   localparam logic [0:0] REG_EMER = 1'd1;

   // Record carried along the chain.
   typedef struct packed {
      logic [1:0]            cond;
      logic [1:0]            prio;
      logic [31:0]           seq;
      logic [RETRY_W-1:0]    retries;
   } rec_type;

   // Command broadcast to every cell during a pass.
   typedef struct packed {
      logic       rotate;
      logic       write;
      logic       erase_all;
      rec_type    wdata;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [1:0]        priority_req;
      logic [31:0]       sequence_req;
      logic [3:0]        slot;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [3:0]            chosen_slot;
      logic [1:0]            chosen_priority;
      logic [31:0]           chosen_sequence;
      logic [7:0]            chosen_retries;
      logic [4:0]            committed_count;
      logic [4:0]            peak_committed;
      logic [15:0]           dropped_count;
      logic [15:0]           saturated_count;
   } rsp_type;
endpackage
`default_nettype wire

>>> src/pssm_if.sv
// Valid/ready channel interface carrying one item.
`default_nettype none
interface pssm_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/pssm_cell.sv
// One slot cell of the rotating record ring.
`default_nettype none
module pssm_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pssm_pkg::cell_ctl_type ctl,
   input  wire logic                  head,
   input  wire pssm_pkg::rec_type     prev_rec,
   output pssm_pkg::rec_type          rec
);
   import pssm_pkg::*;
   rec_type rec_ff, rec_in;
   logic [1:0] cond_ff, cond_in;

   // The head cell takes the controller's write data while the ring rotates.
   always_comb begin
      rec_in = rec_ff;
      cond_in = cond_ff;
      if (ctl.rotate) begin
         if (head && ctl.write) begin
            rec_in = ctl.wdata;
            cond_in = ctl.wdata.cond;
         end else begin
            rec_in = prev_rec;
            cond_in = prev_rec.cond;
         end
      end
      if (ctl.erase_all) cond_in = COND_ERASED;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) cond_ff <= COND_ERASED;
      else cond_ff <= cond_in;
   end

   always_comb begin
      rec = rec_ff;
      rec.cond = cond_ff;
   end
endmodule
`default_nettype wire

>>> src/pssm_ring.sv
// Ring of slot cells; the head cell holds the slot at the scan position.
`default_nettype none
module pssm_ring (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pssm_pkg::cell_ctl_type ctl,
   output pssm_pkg::rec_type           head_rec
);
   import pssm_pkg::*;
   rec_type recs [SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      // Data moves from cell i+1 into cell i; the last cell refills from the head.
      pssm_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .head(i == SLOTS - 1),
         .prev_rec(recs[(i + 1) % SLOTS]), .rec(recs[i])
      );
   end

   assign head_rec = recs[0];
endmodule
`default_nettype wire

>>> src/priority_spool_slot_manager_core.sv
// Top level of the priority spool slot manager: controller, ring and registers.
// Each item passes through an accept state, a scan in which the ring rotates once through
// the head cell, and a done state that forms the result once the output register is free.
// A new item is accepted only after the result of the last one has been formed.
// Synchronous active-high reset erases every slot, clears counters and sets the
// reserves to 2 and 1; the result register may hold a result while a new item is accepted.
`default_nettype none
module priority_spool_slot_manager_core (
   input  wire logic  clock,
   input  wire logic  reset,
   pssm_if.sink       req,
   pssm_if.source     rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pssm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [SLOT_W:0] cnt_ff, cnt_in;
   req_type cmd_ff, cmd_in;
   logic [4:0] rcrit_ff, rcrit_in, remer_ff, remer_in;
   logic [4:0] wm_ff, wm_in;
   logic [15:0] drop_ff, drop_in, sat_ff, sat_in;
   logic found_ff, found_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   rec_type best_rec_ff, best_rec_in;
   logic [CNT_W-1:0] ncomm_ff, ncomm_in;
   logic any_cons_ff, any_cons_in;
   logic [8:0] limit_ff, limit_in;
   rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   cell_ctl_type ctl;
   rec_type head;
   logic [SLOT_W-1:0] pos;
   logic [4:0] reserve;
   logic [RETRY_W-1:0] r_cur;
   logic csr_wr;
   logic [31:0] seq_diff;

   pssm_ring u_ring (.clock(clock), .reset(reset), .ctl(ctl), .head_rec(head));

   assign pos = cnt_ff[SLOT_W-1:0];
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
   assign r_cur = head.retries;
   assign seq_diff = head.seq - best_rec_ff.seq;
   assign reserve = (req.payload.priority_req == 2'd1) ? remer_ff : rcrit_ff;

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_EMER) csr_prdata = {27'd0, remer_ff};
      else csr_prdata = {27'd0, rcrit_ff};
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; cmd_in = cmd_ff;
      rcrit_in = rcrit_ff; remer_in = remer_ff;
      wm_in = wm_ff; drop_in = drop_ff; sat_in = sat_ff;
      found_in = found_ff; best_in = best_ff; best_rec_in = best_rec_ff;
      ncomm_in = ncomm_ff; any_cons_in = any_cons_ff; limit_in = limit_ff;
      out_in = out_ff; out_valid_in = out_valid_ff;
      ctl = '0;
      ctl.wdata = head;
      if (rsp.valid && rsp.ready) out_valid_in = 1'b0;
      if (csr_wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_CRIT) rcrit_in = csr_pwdata[4:0];
         else remer_in = csr_pwdata[4:0];
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.payload;
               cnt_in = '0; found_in = 1'b0; best_in = '0; best_rec_in = '0;
               ncomm_in = '0; any_cons_in = 1'b0;
               if (req.payload.priority_req == 2'd0) limit_in = 9'(SLOTS);
               else if (32'(reserve) >= 32'(SLOTS)) limit_in = '0;
               else limit_in = 9'(SLOTS) - 9'(reserve);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.rotate = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            case (cmd_ff.command)
               CMD_APPEND: begin
                  if (!found_ff && head.cond == COND_ERASED
                      && 9'(pos) < limit_ff) begin
                     found_in = 1'b1; best_in = pos;
                     ctl.write = 1'b1;
                     ctl.wdata.cond = COND_COMMITTED;
                     ctl.wdata.prio = cmd_ff.priority_req;
                     ctl.wdata.seq = cmd_ff.sequence_req;
                     ctl.wdata.retries = '1;
                     best_rec_in = ctl.wdata;
                  end
               end
               CMD_SELECT: begin
                  if (head.cond == COND_COMMITTED && (!found_ff
                      || head.prio < best_rec_ff.prio
                      || (head.prio == best_rec_ff.prio && seq_diff[31]))) begin
                     found_in = 1'b1; best_in = pos; best_rec_in = head;
                  end
               end
               CMD_ACK, CMD_FAIL: begin
                  if (pos == cmd_ff.slot[SLOT_W-1:0] && head.cond != COND_ERASED) begin
                     found_in = 1'b1; best_in = pos;
                     ctl.write = 1'b1;
                     if (cmd_ff.command == CMD_ACK) ctl.wdata.cond = COND_CONSUMED;
                     else if (r_cur == '0) begin
                        if (sat_ff != 16'hffff) sat_in = sat_ff + 1'b1;
                     end else ctl.wdata.retries = r_cur & (r_cur - 1'b1);
                     best_rec_in = ctl.wdata;
                  end
               end
               default: ;
            endcase
            if (ctl.write ? ctl.wdata.cond == COND_COMMITTED
                          : head.cond == COND_COMMITTED)
               ncomm_in = ncomm_ff + 1'b1;
            if (head.cond == COND_CONSUMED) any_cons_in = 1'b1;
            if (cnt_ff == (SLOT_W + 1)'(SLOTS - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in = '0;
               out_in.committed_count = 5'(ncomm_ff);
               case (cmd_ff.command)
                  CMD_APPEND: begin
                     if (!found_ff) begin
                        out_in.status = ST_NOSPACE;
                        if (drop_ff != 16'hffff) drop_in = drop_ff + 1'b1;
                     end else if (5'(ncomm_ff) > wm_ff) wm_in = 5'(ncomm_ff);
                  end
                  CMD_SELECT, CMD_ACK, CMD_FAIL:
                     if (!found_ff) out_in.status = ST_NONE;
                  CMD_RECLAIM:
                     if (ncomm_ff == '0 && any_cons_ff) ctl.erase_all = 1'b1;
                  default: ;
               endcase
               if (found_ff && cmd_ff.command != CMD_RECLAIM) begin
                  out_in.chosen_slot = 4'(best_ff);
                  out_in.chosen_priority = best_rec_ff.prio;
                  out_in.chosen_sequence = best_rec_ff.seq;
                  out_in.chosen_retries = 8'(best_rec_ff.retries);
               end
               out_in.peak_committed = wm_in;
               out_in.dropped_count = drop_in;
               out_in.saturated_count = sat_in;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; best_ff <= best_in; best_rec_ff <= best_rec_in;
      limit_ff <= limit_in; out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; rcrit_ff <= 5'd2; remer_ff <= 5'd1;
         wm_ff <= '0; drop_ff <= '0; sat_ff <= '0; found_ff <= 1'b0;
         ncomm_ff <= '0; any_cons_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rcrit_ff <= rcrit_in; remer_ff <= remer_in;
         wm_ff <= wm_in; drop_ff <= drop_in; sat_ff <= sat_in; found_ff <= found_in;
         ncomm_ff <= ncomm_in; any_cons_ff <= any_cons_in; out_valid_ff <= out_valid_in;
      end
   end

   a_wm_ge_count: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.status == ST_OK && cmd_ff.command == CMD_APPEND
       && state_ff == S_IDLE)
      |-> rsp.payload.peak_committed >= rsp.payload.committed_count)
      else $error("watermark below committed count");
   a_ring_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      ctl.rotate |-> state_ff == S_SCAN)
      else $error("ring rotated outside scan");
   a_result_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without finished scan");
endmodule
`default_nettype wire
